// ===== design/cbn_pkg.sv =====
package cbn_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned LINE_BITS_DEF   = 16;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned LINE_OUT_W      = 16;

  typedef enum logic [1:0] {
    KIND_ECHO     = 2'd0,
    KIND_MISMATCH = 2'd1,
    KIND_OK       = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    BR_LPAREN = 2'd0,
    BR_RPAREN = 2'd1,
    BR_LBRACE = 2'd2,
    BR_RBRACE = 2'd3
  } bracket_e;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } op_e;

  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;

endpackage

// ===== design/cbn_in_if.sv =====
interface cbn_in_if;
  logic                         valid;
  logic                         ready;
  cbn_pkg::op_e                 op;
  logic [cbn_pkg::CHAR_W-1:0]   char_code;

  modport source (output valid, output op, output char_code, input ready);
  modport sink   (input valid, input op, input char_code, output ready);
endinterface

// ===== design/cbn_out_if.sv =====
interface cbn_out_if;
  logic                             valid;
  logic                             ready;
  cbn_pkg::kind_e                   kind;
  cbn_pkg::bracket_e                bracket;
  logic [cbn_pkg::LINE_OUT_W-1:0]   line_number;

  modport source (output valid, output kind, output bracket, output line_number, input ready);
  modport sink   (input valid, input kind, input bracket, input line_number, output ready);
endinterface

// ===== design/cbn_ram.sv =====
module cbn_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/c_bracket_nesting_checker.sv =====
// Channel  Dir  Payload                          Transfer
// in_i     in   op, char_code                    valid & ready
// out_o    out  kind, bracket, line_number       valid & ready
//
// One character or end marker per cycle while in_i.ready is high; each transaction is
// fully processed in its accept cycle, and any result appears on out_o in the next cycle
// from an output register. Top of stack sits in flops; the entry below it is pre-read
// from the RAM every cycle, with forwarding when that entry is being written.
// in_i.ready drops only while a result waits and out_o.ready is low.
// Reset clears lexer mode, line count (to 1), depth and halt; the stack RAM is not cleared.
module c_bracket_nesting_checker #(
  parameter int unsigned STACK_DEPTH = cbn_pkg::STACK_DEPTH_DEF,
  parameter int unsigned LINE_BITS   = cbn_pkg::LINE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbn_in_if.sink      in_i,
  cbn_out_if.source   out_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EW = LINE_BITS + 1;

  localparam logic [2:0] MODE_NORMAL     = 3'd0;
  localparam logic [2:0] MODE_SLASH      = 3'd1;
  localparam logic [2:0] MODE_LINE_CMT   = 3'd2;
  localparam logic [2:0] MODE_BLOCK_CMT  = 3'd3;
  localparam logic [2:0] MODE_BLOCK_STAR = 3'd4;
  localparam logic [2:0] MODE_SQUOTE     = 3'd5;
  localparam logic [2:0] MODE_DQUOTE     = 3'd6;

  logic [2:0]           mode_q, mode_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [DW-1:0]        depth_q, depth_d;
  logic                 halted_q, halted_d;
  logic                 top_brace_q, top_brace_d;
  logic [LINE_BITS-1:0] top_line_q, top_line_d;
  logic                 fwd_q, fwd_d;
  logic [EW-1:0]        fwd_data_q;

  logic                 out_valid_q, out_valid_d;
  cbn_pkg::kind_e       out_kind_q, e_kind;
  cbn_pkg::bracket_e    out_br_q, e_br;
  logic [cbn_pkg::LINE_OUT_W-1:0] out_line_q, e_line_out;

  logic                 in_acc;
  logic                 emit;
  logic [LINE_BITS-1:0] e_line;
  logic [31:0]          e_line_ext;
  logic                 norm, do_push, do_pop, arg_brace;
  logic [EW-1:0]        below;
  logic                 below_brace;
  logic [LINE_BITS-1:0] below_line;

  logic                 ram_we;
  logic [EW-1:0]        ram_wdata, ram_rdata;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [DW-1:0]        depth_m1, depth_d_m2;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  assign below       = fwd_q ? fwd_data_q : ram_rdata;
  assign below_brace = below[EW-1];
  assign below_line  = below[LINE_BITS-1:0];

  assign depth_m1   = depth_q - DW'(1);
  assign depth_d_m2 = depth_d - DW'(2);
  assign ram_waddr  = depth_m1[AW-1:0];
  assign ram_raddr  = depth_d_m2[AW-1:0];
  assign ram_wdata  = {top_brace_q, top_line_q};

  always_comb begin
    mode_d      = mode_q;
    line_d      = line_q;
    depth_d     = depth_q;
    halted_d    = halted_q;
    top_brace_d = top_brace_q;
    top_line_d  = top_line_q;
    emit        = 1'b0;
    e_kind      = cbn_pkg::KIND_ECHO;
    e_br        = cbn_pkg::BR_LPAREN;
    e_line      = line_q;
    norm        = 1'b0;
    do_push     = 1'b0;
    do_pop      = 1'b0;
    arg_brace   = 1'b0;
    ram_we      = 1'b0;

    if (in_acc && !halted_q) begin
      if (in_i.op == cbn_pkg::OP_END) begin
        if (mode_q == MODE_SLASH) begin
          mode_d = MODE_NORMAL;
        end
        emit = 1'b1;
        if (depth_q != '0) begin
          halted_d = 1'b1;
          e_kind   = cbn_pkg::KIND_MISMATCH;
          e_br     = top_brace_q ? cbn_pkg::BR_LBRACE : cbn_pkg::BR_LPAREN;
          e_line   = top_line_q;
        end else begin
          e_kind = cbn_pkg::KIND_OK;
          e_line = '0;
        end
      end else begin
        case (mode_q)
          MODE_SLASH: begin
            if (in_i.char_code == cbn_pkg::CH_SLASH) begin
              mode_d = MODE_LINE_CMT;
            end else if (in_i.char_code == cbn_pkg::CH_STAR) begin
              mode_d = MODE_BLOCK_CMT;
            end else begin
              mode_d = MODE_NORMAL;
              norm   = 1'b1;
            end
          end
          MODE_LINE_CMT: begin
            if (in_i.char_code == cbn_pkg::CH_NL) mode_d = MODE_NORMAL;
          end
          MODE_BLOCK_CMT: begin
            if (in_i.char_code == cbn_pkg::CH_STAR) begin
              mode_d = MODE_BLOCK_STAR;
            end else if (in_i.char_code == cbn_pkg::CH_NL) begin
              mode_d = MODE_NORMAL;
            end
          end
          MODE_BLOCK_STAR: begin
            if (in_i.char_code == cbn_pkg::CH_SLASH || in_i.char_code == cbn_pkg::CH_NL) begin
              mode_d = MODE_NORMAL;
            end else if (in_i.char_code != cbn_pkg::CH_STAR) begin
              mode_d = MODE_BLOCK_CMT;
            end
          end
          MODE_SQUOTE: begin
            if (in_i.char_code == cbn_pkg::CH_SQUOTE || in_i.char_code == cbn_pkg::CH_NL) begin
              mode_d = MODE_NORMAL;
            end
          end
          MODE_DQUOTE: begin
            if (in_i.char_code == cbn_pkg::CH_DQUOTE || in_i.char_code == cbn_pkg::CH_NL) begin
              mode_d = MODE_NORMAL;
            end
          end
          default: begin
            mode_d = MODE_NORMAL;
            norm   = 1'b1;
          end
        endcase

        if (norm) begin
          case (in_i.char_code)
            cbn_pkg::CH_SLASH:  mode_d = MODE_SLASH;
            cbn_pkg::CH_SQUOTE: mode_d = MODE_SQUOTE;
            cbn_pkg::CH_DQUOTE: mode_d = MODE_DQUOTE;
            cbn_pkg::CH_LPAREN: do_push = 1'b1;
            cbn_pkg::CH_LBRACE: begin
              arg_brace = 1'b1;
              // a brace opened inside a paren is reported against that paren
              if (depth_q != '0 && !top_brace_q) begin
                emit     = 1'b1;
                halted_d = 1'b1;
                e_kind   = cbn_pkg::KIND_MISMATCH;
                e_br     = cbn_pkg::BR_LPAREN;
                e_line   = top_line_q;
              end else begin
                do_push = 1'b1;
              end
            end
            cbn_pkg::CH_RPAREN: do_pop = 1'b1;
            cbn_pkg::CH_RBRACE: begin
              do_pop    = 1'b1;
              arg_brace = 1'b1;
            end
            default: ;
          endcase
        end

        if (do_push) begin
          emit = 1'b1;
          e_br = arg_brace ? cbn_pkg::BR_LBRACE : cbn_pkg::BR_LPAREN;
          if (depth_q == DW'(STACK_DEPTH)) begin
            halted_d = 1'b1;
            e_kind   = cbn_pkg::KIND_OVERFLOW;
          end else begin
            // spill the cached top into the RAM, cache the new opener
            ram_we      = depth_q != '0;
            depth_d     = depth_q + DW'(1);
            top_brace_d = arg_brace;
            top_line_d  = line_q;
          end
        end

        if (do_pop) begin
          emit = 1'b1;
          e_br = arg_brace ? cbn_pkg::BR_RBRACE : cbn_pkg::BR_RPAREN;
          if (depth_q == '0 || top_brace_q != arg_brace) begin
            halted_d = 1'b1;
            e_kind   = cbn_pkg::KIND_MISMATCH;
          end else begin
            depth_d     = depth_m1;
            top_brace_d = below_brace;
            top_line_d  = below_line;
          end
        end

        if (in_i.char_code == cbn_pkg::CH_NL && line_q != '1) begin
          line_d = line_q + LINE_BITS'(1);
        end
      end
    end
  end

  // forward the spilled entry when it is the one being pre-read
  assign fwd_d = ram_we && (ram_waddr == ram_raddr);

  assign e_line_ext = 32'(e_line);
  assign e_line_out = e_line_ext[cbn_pkg::LINE_OUT_W-1:0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NORMAL;
      line_q      <= LINE_BITS'(1);
      depth_q     <= '0;
      halted_q    <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      line_q      <= line_d;
      depth_q     <= depth_d;
      halted_q    <= halted_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_brace_q <= top_brace_d;
    top_line_q  <= top_line_d;
    fwd_data_q  <= ram_wdata;
    if (emit) begin
      out_kind_q <= e_kind;
      out_br_q   <= e_br;
      out_line_q <= e_line_out;
    end
  end

  cbn_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.bracket     = out_br_q;
  assign out_o.line_number = out_line_q;

`ifndef SYNTHESIS
  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt released without reset");

  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_fwd_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> $past(ram_we))
    else $error("forwarding without a preceding spill");

  a_halted_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> $stable(depth_q) && $stable(line_q))
    else $error("state changed while halted");
`endif

endmodule
